[design/adcavg_pkg.sv]
// Shared constants, codes and types of the ADC channel average and calibration block.
`default_nettype none
package adcavg_pkg;

  localparam int CHANNELS       = 16;
  localparam int SMOOTH_SHIFT   = 3;
  localparam int TEMP_CHANNEL   = 10;
  localparam int SUPPLY_CHANNEL = 11;

  localparam int ACC_W  = 16;
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AVG_W  = ACC_W + 1 - SMOOTH_SHIFT;
  localparam int DIFF_W = AVG_W + 1;
  localparam int RND    = 1 << (SMOOTH_SHIFT - 1);

  localparam int T_LO       = 30;
  localparam int T_HI       = 85;
  localparam int T_SPAN     = T_HI - T_LO;
  localparam int T_MAX      = 255;
  localparam int QUOT_W     = 20;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CODE_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 16;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_READ   = 3'd1,
    OP_TEMP   = 3'd2,
    OP_SUPPLY = 3'd3,
    OP_SCALE  = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_REF    = 3'd2,
    REG_CAL30  = 3'd3,
    REG_CAL85  = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_SAMPLE,
    CMD_MUL_GAIN,
    CMD_OFFSET,
    CMD_MUL_REF,
    CMD_FIVE,
    CMD_MUL_SV,
    CMD_SCALE,
    CMD_TEMP_MUL,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_TEMP_FIN,
    CMD_PUSH
  } cmd_e;

  typedef enum logic [1:0] {
    CH_ITEM,
    CH_SUPPLY,
    CH_TEMP
  } chsel_e;

  typedef struct packed {
    logic   load;
    cmd_e   cmd;
    chsel_e chsel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic [AVG_W-1:0] avg_of(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + (ACC_W+1)'(RND);
    return sum[ACC_W:SMOOTH_SHIFT];
  endfunction

endpackage
`default_nettype wire

[design/adcavg_ctrl.sv]
// Sequencer that steps the datapath through each request's operations.
`default_nettype none
module adcavg_ctrl
  import adcavg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] opcode_i,
  output logic            in_stall_o,
  output ctrl_cmd_t       cmd_o,
  input  dp_stat_t        stat_i
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SAMP  = 13'b0000000000010,
    S_MULG  = 13'b0000000000100,
    S_OFFS  = 13'b0000000001000,
    S_MULR  = 13'b0000000010000,
    S_FIVE  = 13'b0000000100000,
    S_MULS  = 13'b0000001000000,
    S_SCALE = 13'b0000010000000,
    S_TMUL  = 13'b0000100000000,
    S_DINIT = 13'b0001000000000,
    S_DIV   = 13'b0010000000000,
    S_TFIN  = 13'b0100000000000,
    S_PUSH  = 13'b1000000000000
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    cmd_o.load  = accept;
    cmd_o.cmd   = CMD_IDLE;
    cmd_o.chsel = CH_ITEM;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_e'(opcode_i);
          unique case (op_e'(opcode_i))
            OP_SAMPLE: state_d = S_SAMP;
            OP_READ:   state_d = S_MULG;
            OP_TEMP:   state_d = S_TMUL;
            OP_SUPPLY: state_d = S_MULG;
            OP_SCALE:  state_d = S_MULG;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SAMP: begin
        cmd_o.cmd = CMD_SAMPLE;
        state_d   = S_IDLE;
      end
      S_MULG: begin
        cmd_o.cmd   = CMD_MUL_GAIN;
        cmd_o.chsel = (op_q == OP_READ) ? CH_ITEM : CH_SUPPLY;
        state_d     = S_OFFS;
      end
      S_OFFS: begin
        cmd_o.cmd = CMD_OFFSET;
        state_d   = (op_q == OP_READ) ? S_PUSH : S_MULR;
      end
      S_MULR: begin
        cmd_o.cmd = CMD_MUL_REF;
        state_d   = S_FIVE;
      end
      S_FIVE: begin
        cmd_o.cmd = CMD_FIVE;
        state_d   = (op_q == OP_SCALE) ? S_MULS : S_PUSH;
      end
      S_MULS: begin
        cmd_o.cmd = CMD_MUL_SV;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.cmd = CMD_SCALE;
        state_d   = S_PUSH;
      end
      S_TMUL: begin
        cmd_o.cmd   = CMD_TEMP_MUL;
        cmd_o.chsel = CH_TEMP;
        state_d     = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.cmd = CMD_DIV_INIT;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.cmd = CMD_DIV_STEP;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_TFIN;
        end
      end
      S_TFIN: begin
        cmd_o.cmd = CMD_TEMP_FIN;
        state_d   = S_PUSH;
      end
      S_PUSH: begin
        // hold the result until the output register can take it
        if (!stat_i.out_busy) begin
          cmd_o.cmd = CMD_PUSH;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_SAMPLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTH
  a_samp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SAMP |=> state_q == S_IDLE)
    else $error("sample update did not return to idle");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> state_q == S_TFIN)
    else $error("divider did not finish after its last step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_SAMPLE || opcode_i == OP_READ || opcode_i == OP_TEMP ||
                opcode_i == OP_SUPPLY || opcode_i == OP_SCALE))
    |=> state_q != S_IDLE)
    else $error("accepted request was dropped");
`endif

endmodule
`default_nettype wire

[design/adcavg_dp.sv]
// Datapath: accumulators, calibration registers, shared multiplier and serial divider.
`default_nettype none
module adcavg_dp
  import adcavg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output dp_stat_t                  stat_o,
  input  wire logic [7:0]           channel_i,
  input  wire logic [CODE_W-1:0]    sample_value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [15:0]               value_o
);

  logic [ACC_W-1:0]  acc_q [CHANNELS];
  logic [15:0]       gain_q, offset_q, ref_q;
  logic [CODE_W-1:0] cal30_q, cal85_q;

  logic [7:0]        ch_q;
  logic [CODE_W-1:0] sv_q;
  logic [31:0]       prod_q;
  logic [15:0]       w_q;
  logic              ok_q, neg_q, zero_q;
  logic [CODE_W-1:0] dvs_q, rem_q;
  logic [QUOT_W-1:0] quot_q;
  logic [15:0]       value_q;
  logic              out_valid_q;

  logic [7:0]        sel_ch;
  logic              sel_ok;
  logic [ACC_W-1:0]  sel_acc;
  logic [AVG_W-1:0]  sel_avg;
  logic [ACC_W-1:0]  acc_new;
  logic [15:0]       mul_a, mul_b;
  logic [31:0]       mul_p;
  logic [DIFF_W-1:0] tdiff, tmag;
  logic [CODE_W:0]   dv;
  logic [CODE_W-1:0] dv_mag;
  logic [17:0]       five;
  logic [CODE_W:0]   shifted, trial;
  logic              ge;
  logic [15:0]       temp_res;

  always_comb begin
    unique case (cmd_i.chsel)
      CH_ITEM:   sel_ch = ch_q;
      CH_SUPPLY: sel_ch = 8'(SUPPLY_CHANNEL);
      CH_TEMP:   sel_ch = 8'(TEMP_CHANNEL);
      default:   sel_ch = ch_q;
    endcase
  end

  assign sel_ok  = (sel_ch < 8'(CHANNELS));
  assign sel_acc = sel_ok ? acc_q[sel_ch[IDX_W-1:0]] : '0;
  assign sel_avg = avg_of(sel_acc);
  assign acc_new = sel_acc + ACC_W'(sv_q) - ACC_W'(sel_avg);

  // temperature: signed code difference and divisor, carried as sign and magnitude
  assign tdiff  = DIFF_W'(sel_avg) - DIFF_W'(cal30_q);
  assign tmag   = tdiff[DIFF_W-1] ? (~tdiff + DIFF_W'(1)) : tdiff;
  assign dv     = {1'b0, cal85_q} - {1'b0, cal30_q};
  assign dv_mag = dv[CODE_W] ? CODE_W'(~dv + (CODE_W+1)'(1)) : dv[CODE_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.cmd)
      CMD_MUL_GAIN: begin
        mul_a = 16'(sel_avg);
        mul_b = gain_q;
      end
      CMD_MUL_REF: begin
        mul_a = w_q;
        mul_b = ref_q;
      end
      CMD_MUL_SV: begin
        mul_a = w_q;
        mul_b = 16'(sv_q);
      end
      CMD_TEMP_MUL: begin
        mul_a = 16'(tmag);
        mul_b = 16'(T_SPAN);
      end
      default: ;
    endcase
  end

  assign mul_p = {16'b0, mul_a} * {16'b0, mul_b};

  assign five = {2'b0, prod_q[30:15]} + {prod_q[30:15], 2'b0};

  // one restoring step; the remainder stays below the divisor whenever the divisor is nonzero
  assign shifted = {rem_q, quot_q[QUOT_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_comb begin
    if (zero_q) begin
      temp_res = 16'(T_MAX);
    end else if (neg_q) begin
      temp_res = (quot_q > QUOT_W'(T_LO)) ? 16'd0 : 16'(QUOT_W'(T_LO) - quot_q);
    end else begin
      temp_res = (quot_q > QUOT_W'(T_MAX - T_LO)) ? 16'(T_MAX)
                                                  : 16'(quot_q + QUOT_W'(T_LO));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q <= channel_i;
      sv_q <= sample_value_i;
    end
    unique case (cmd_i.cmd)
      CMD_MUL_GAIN, CMD_MUL_REF, CMD_MUL_SV: prod_q <= mul_p;
      CMD_TEMP_MUL: begin
        prod_q <= mul_p;
        neg_q  <= tdiff[DIFF_W-1] ^ dv[CODE_W];
        zero_q <= (cal85_q == cal30_q);
        dvs_q  <= dv_mag;
      end
      CMD_DIV_INIT: begin
        rem_q  <= '0;
        quot_q <= prod_q[QUOT_W-1:0];
      end
      CMD_DIV_STEP: begin
        rem_q  <= ge ? trial[CODE_W-1:0] : shifted[CODE_W-1:0];
        quot_q <= {quot_q[QUOT_W-2:0], ge};
      end
      CMD_OFFSET:   w_q <= ok_q ? (16'(prod_q[29:15]) + offset_q) : 16'd0;
      CMD_FIVE:     w_q <= five[17:2];
      CMD_SCALE:    w_q <= prod_q[27:12];
      CMD_TEMP_FIN: w_q <= temp_res;
      CMD_PUSH:     value_q <= w_q;
      default: ;
    endcase
    if (cmd_i.cmd == CMD_MUL_GAIN) begin
      ok_q <= sel_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc_q[i] <= '0;
      end
      gain_q      <= 16'd32768;
      offset_q    <= '0;
      ref_q       <= 16'd32768;
      cal30_q     <= '0;
      cal85_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cmd == CMD_SAMPLE && sel_ok) begin
        acc_q[sel_ch[IDX_W-1:0]] <= acc_new;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GAIN:   gain_q   <= cfg_wdata_i;
          REG_OFFSET: offset_q <= cfg_wdata_i;
          REG_REF:    ref_q    <= cfg_wdata_i;
          REG_CAL30:  cal30_q  <= cfg_wdata_i[CODE_W-1:0];
          REG_CAL85:  cal85_q  <= cfg_wdata_i[CODE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.cmd == CMD_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign value_o         = value_q;

`ifndef SYNTH
  a_valid_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.cmd == CMD_PUSH))
    else $error("result valid without a push");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_PUSH |-> !(out_valid_q && out_stall_i))
    else $error("push over a result still waiting");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == CMD_DIV_STEP && !zero_q) |-> rem_q < dvs_q)
    else $error("divider remainder out of range");
`endif

endmodule
`default_nettype wire

[design/adc_channel_average_calibrate_top.sv]
// Top level of the ADC channel average and calibration block.
// One request is in flight at a time; a new one is taken only when the sequencer is idle.
// Steps: sample updates an accumulator; read applies gain and offset; supply then applies
// reference and five quarters; scaled also multiplies by the sample; temperature divides.
// A result sits in an output register, so the next request can start while it waits.
// Reset (async, active low) zeroes the accumulators and loads the calibration defaults.
`default_nettype none
module adc_channel_average_calibrate_top
  import adcavg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [2:0]           opcode_i,
  input  wire logic [7:0]           channel_i,
  input  wire logic [CODE_W-1:0]    sample_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [15:0]               value_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  adcavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  adcavg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .channel_i      (channel_i),
    .sample_value_i (sample_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o)
  );

endmodule
`default_nettype wire

[tb/tb_adc_channel_average_calibrate_top.sv]
// Self-checking testbench for the ADC channel average and calibration block.
`default_nettype none
module tb_adc_channel_average_calibrate_top;
  import adcavg_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 5;
  localparam int GAP_MAX        = 18;
  localparam int SETTLE_CYCLES  = 40;   // longest request is the temperature one
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 200;
  localparam int TIMEOUT_CYCLES = 600000;

  localparam logic [2:0]           OP_SPARE_LO  = 3'd5;
  localparam logic [2:0]           OP_SPARE_MID = 3'd6;
  localparam logic [2:0]           OP_SPARE_HI  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Tracks channel accumulators and calibration registers, and holds the
  // readings the block still owes, oldest first.
  class adc_calib_scoreboard;
    logic [ACC_W-1:0]  acc [CHANNELS];
    logic [15:0]       gain;
    logic [15:0]       offs;
    logic [15:0]       refk;
    logic [CODE_W-1:0] cal30;
    logic [CODE_W-1:0] cal85;
    logic [15:0]       readings_due [$];
    int                errors;

    function new();
      foreach (acc[i]) acc[i] = '0;
      gain   = 16'h8000;
      offs   = '0;
      refk   = 16'h8000;
      cal30  = '0;
      cal85  = '1;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] %s", $time, msg);
      errors++;
    endtask

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
        REG_GAIN:   gain = data;
        REG_OFFSET: offs = data;
        REG_REF:    refk = data;
        REG_CAL30:  cal30 = data[CODE_W-1:0];
        REG_CAL85:  cal85 = data[CODE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] mean(input int unsigned ch);
      if (ch >= CHANNELS) return '0;
      return (32'(acc[ch]) + RND) >> SMOOTH_SHIFT;
    endfunction

    function logic [15:0] calibrated(input int unsigned ch);
      logic [31:0] p;
      if (ch >= CHANNELS) return '0;
      p = (mean(ch) * 32'(gain)) >> 15;
      return 16'(p + 32'(offs));
    endfunction

    function logic [15:0] degrees();
      int m;
      int d;
      int r;
      m = int'(mean(TEMP_CHANNEL));
      d = int'(cal85) - int'(cal30);
      if (d == 0) return 16'(T_MAX);
      // int division truncates toward zero
      r = (m - int'(cal30)) * T_SPAN / d + T_LO;
      if (r < 0) return '0;
      if (r > T_MAX) return 16'(T_MAX);
      return 16'(r);
    endfunction

    function logic [15:0] supply_level();
      logic [31:0] c;
      c = (32'(calibrated(SUPPLY_CHANNEL)) * 32'(refk)) >> 15;
      c = c & 32'h0000_FFFF;
      return 16'((c * 32'd5) >> 2);
    endfunction

    function void take_request(input logic [2:0] op, input logic [7:0] ch,
                               input logic [CODE_W-1:0] sv);
      logic [31:0] nxt;
      case (op)
        OP_SAMPLE: begin
          if (ch < CHANNELS) begin
            nxt = 32'(acc[ch]) + 32'(sv) - mean(ch);
            acc[ch] = nxt[ACC_W-1:0];
          end
        end
        OP_READ:   readings_due.push_back(calibrated(ch));
        OP_TEMP:   readings_due.push_back(degrees());
        OP_SUPPLY: readings_due.push_back(supply_level());
        OP_SCALE: begin
          nxt = (32'(supply_level()) * 32'(sv)) >> 12;
          readings_due.push_back(nxt[15:0]);
        end
        default: ;
      endcase
    endfunction

    task check_reading(input logic [15:0] v);
      logic [15:0] want;
      if (readings_due.size() == 0) begin
        report($sformatf("result %h with no request outstanding", v));
        return;
      end
      want = readings_due.pop_front();
      if (v !== want) report($sformatf("value mismatch: expected %h, got %h", want, v));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           opcode;
  logic [7:0]           channel;
  logic [CODE_W-1:0]    sample_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [15:0]          value;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  adc_calib_scoreboard sb;
  bit no_gaps;
  bit hold_long;
  int sv_lo;
  int sv_hi;

  adc_channel_average_calibrate_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .channel_i      (channel),
    .sample_value_i (sample_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .value_o        (value),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  function automatic int pick_gap();
    if (no_gaps) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Offer one request; returns at the edge where it is taken.
  task automatic send_request(input logic [2:0] op, input logic [7:0] ch,
                              input logic [CODE_W-1:0] sv);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    channel      <= ch;
    sample_value <= sv;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sb.take_request(op, ch, sv);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Upper bits of the 12-bit registers get random junk to check they are dropped.
  task automatic program_regs(input logic [15:0] g, input logic [15:0] o, input logic [15:0] r,
                              input logic [CODE_W-1:0] c30, input logic [CODE_W-1:0] c85);
    write_reg(REG_GAIN, g);
    write_reg(REG_OFFSET, o);
    write_reg(REG_REF, r);
    write_reg(REG_CAL30, {4'($urandom), c30});
    write_reg(REG_CAL85, {4'($urandom), c85});
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_request(output bit counted);
    int unsigned pick;
    logic [2:0] op;
    logic [7:0] ch;
    logic [CODE_W-1:0] sv;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_SAMPLE;
    else if (pick < 60) op = OP_READ;
    else if (pick < 72) op = OP_TEMP;
    else if (pick < 84) op = OP_SUPPLY;
    else if (pick < 96) op = OP_SCALE;
    else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    pick = $urandom_range(0, 9);
    if (pick == 0) ch = 8'($urandom_range(CHANNELS, 255));
    else if (pick < 3) ch = 8'(TEMP_CHANNEL);
    else if (pick < 5) ch = 8'(SUPPLY_CHANNEL);
    else ch = 8'($urandom_range(0, CHANNELS - 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) sv = '0;
    else if (pick == 1) sv = '1;
    else sv = CODE_W'($urandom_range(sv_lo, sv_hi));
    send_request(op, ch, sv);
    counted = !(op >= OP_SPARE_LO || (op == OP_SAMPLE && ch >= CHANNELS));
  endtask

  task automatic run_phase(input logic [15:0] g, input logic [15:0] o, input logic [15:0] r,
                           input logic [CODE_W-1:0] c30, input logic [CODE_W-1:0] c85,
                           input int lo, input int hi, input bit quiet, input bit hold);
    int n;
    bit counted;
    program_regs(g, o, r, c30, c85);
    sv_lo     = lo;
    sv_hi     = hi;
    no_gaps   = quiet;
    hold_long = hold;
    n = 0;
    while (n < PHASE_ITEMS) begin
      random_request(counted);
      if (counted) n++;
    end
    drain();
    no_gaps = 1'b0;
  endtask

  // Result side: random hold-offs, one long one on request.
  initial begin
    int gap;
    bit got;
    logic [15:0] v;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (hold_long) begin
        hold_long = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      got = 1'b0;
      while (!got) begin
        @(negedge clk);
        got = out_valid;
        v   = value;
        @(posedge clk);
      end
      sb.check_reading(v);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [CODE_W-1:0] code;
    sb           = new();
    no_gaps      = 1'b0;
    hold_long    = 1'b0;
    sv_lo        = 0;
    sv_hi        = 4095;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    opcode       = '0;
    channel      = '0;
    sample_value = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset calibration, empty and invalid channels, every opcode
    send_request(OP_READ, 8'd0, '0);
    send_request(OP_READ, 8'(CHANNELS - 1), '1);
    send_request(OP_READ, 8'(CHANNELS), '0);
    send_request(OP_READ, 8'hFF, '1);
    send_request(OP_TEMP, '0, '0);
    send_request(OP_SUPPLY, '0, '0);
    send_request(OP_SCALE, '0, '1);
    send_request(OP_SAMPLE, 8'd0, '1);
    send_request(OP_SAMPLE, 8'd0, '1);
    send_request(OP_READ, 8'd0, '0);
    send_request(OP_SAMPLE, 8'(TEMP_CHANNEL), '1);
    send_request(OP_SAMPLE, 8'(SUPPLY_CHANNEL), '1);
    send_request(OP_SAMPLE, 8'(SUPPLY_CHANNEL), 12'hAAA);
    send_request(OP_TEMP, 8'hFF, 12'h555);
    send_request(OP_SUPPLY, 8'hFF, '1);
    send_request(OP_SCALE, '0, '0);
    send_request(OP_SCALE, '0, 12'h555);
    // samples to channels that do not exist must leave everything alone
    send_request(OP_SAMPLE, 8'(CHANNELS), '1);
    send_request(OP_SAMPLE, 8'hFF, 12'hAAA);
    send_request(OP_SPARE_LO, 8'd1, '1);
    send_request(OP_SPARE_MID, 8'(SUPPLY_CHANNEL), '1);
    send_request(OP_SPARE_HI, 8'hFF, '1);
    send_request(OP_SAMPLE, 8'(CHANNELS - 1), '0);
    send_request(OP_READ, 8'(CHANNELS - 1), '0);
    send_request(OP_SUPPLY, '0, '0);
    drain();

    // top of the gain, reference and sample ranges: large averages and a large offset
    run_phase(16'hFFFF, 16'h7FFF, 16'hFFFF, 12'h000, 12'hFFF, 3800, 4095, 1'b0, 1'b0);
    // bottom of the gain, reference and sample ranges, negative temperature slope
    run_phase(16'h0000, 16'h8000, 16'h0000, 12'hFFF, 12'h000, 0, 300, 1'b0, 1'b0);
    // equal temperature codes
    code = CODE_W'($urandom);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), code, code, 0, 4095, 1'b0, 1'b0);
    // tiny divisor pushes temperature to the clamp; no idling on either side
    run_phase(16'h8000, 16'h0000, 16'h8000, 12'h000, 12'h001, 0, 4095, 1'b1, 1'b0);
    // receiver holds off long enough to back up the input
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), CODE_W'($urandom),
              CODE_W'($urandom), 0, 4095, 1'b0, 1'b1);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), CODE_W'($urandom),
              CODE_W'($urandom), 2000, 4095, 1'b0, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), CODE_W'($urandom_range(0, 600)),
              CODE_W'($urandom_range(1500, 4095)), 0, 4095, 1'b0, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), CODE_W'($urandom),
              CODE_W'($urandom), 0, 1000, 1'b0, 1'b0);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
